/* design/dccd_pkg.sv */
`default_nettype none
package dccd_pkg;

    localparam int TICK_BITS = 16;
    localparam int CFG_BITS  = 16;
    localparam int BYTE_BITS = 8;
    localparam int CNT_BITS  = 8;
    localparam int BITS_LEFT_BITS = 4;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_BITS-1:0] ZERO_MIN_RESET  = CFG_BITS'(90 * 2);
    localparam logic [CFG_BITS-1:0] ONE_MIN_RESET   = CFG_BITS'(52 * 2);
    localparam logic [CFG_BITS-1:0] ONE_MAX_RESET   = CFG_BITS'(64 * 2);
    localparam logic [CFG_BITS-1:0] ONE_DELTA_RESET = CFG_BITS'(6 * 2);
    localparam logic [CNT_BITS-1:0] PREAMBLE_RESET  = CNT_BITS'(20);
    localparam logic [CNT_BITS-1:0] PREAMBLE_SAT    = {CNT_BITS{1'b1}};
    localparam logic [BITS_LEFT_BITS-1:0] BITS_PER_BYTE = BITS_LEFT_BITS'(BYTE_BITS);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ZERO_MIN  = 3'd0,
        REG_ONE_MIN   = 3'd1,
        REG_ONE_MAX   = 3'd2,
        REG_ONE_DELTA = 3'd3,
        REG_PREAMBLE  = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_SEEK  = 2'd0,
        PH_START = 2'd1,
        PH_A     = 2'd2,
        PH_B     = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_DATA   = 3'd0,
        ST_OK     = 3'd1,
        ST_CHECK  = 3'd2,
        ST_BADLEN = 3'd3,
        ST_MATCH  = 3'd4,
        ST_DELTA  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_ONE  = 2'd1,
        CLS_BAD  = 2'd2
    } half_class_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] zero_min;
        logic [CFG_BITS-1:0] one_min;
        logic [CFG_BITS-1:0] one_max;
        logic [CFG_BITS-1:0] one_delta_max;
        logic [CNT_BITS-1:0] preamble_min;
    } cfg_t;

endpackage
`default_nettype wire

/* design/dccd_cfg.sv */
`default_nettype none
module dccd_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    input  wire logic [dccd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [dccd_pkg::CFG_BITS-1:0]       cfg_data,
    output dccd_pkg::cfg_t                           cfg
);

    dccd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_min      <= dccd_pkg::ZERO_MIN_RESET;
            cfg_reg.one_min       <= dccd_pkg::ONE_MIN_RESET;
            cfg_reg.one_max       <= dccd_pkg::ONE_MAX_RESET;
            cfg_reg.one_delta_max <= dccd_pkg::ONE_DELTA_RESET;
            cfg_reg.preamble_min  <= dccd_pkg::PREAMBLE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dccd_pkg::REG_ZERO_MIN:  cfg_reg.zero_min      <= cfg_data;
                dccd_pkg::REG_ONE_MIN:   cfg_reg.one_min       <= cfg_data;
                dccd_pkg::REG_ONE_MAX:   cfg_reg.one_max       <= cfg_data;
                dccd_pkg::REG_ONE_DELTA: cfg_reg.one_delta_max <= cfg_data;
                dccd_pkg::REG_PREAMBLE:
                    cfg_reg.preamble_min <= cfg_data[dccd_pkg::CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

/* design/dccd_classify.sv */
`default_nettype none
module dccd_classify (
    input  wire logic [dccd_pkg::TICK_BITS-1:0] len,
    input  wire dccd_pkg::cfg_t                 cfg,
    output dccd_pkg::half_class_t               half_class
);

    // zero test wins when the ranges overlap
    always_comb begin
        if (len >= cfg.zero_min) begin
            half_class = dccd_pkg::CLS_ZERO;
        end else if (len >= cfg.one_min && len <= cfg.one_max) begin
            half_class = dccd_pkg::CLS_ONE;
        end else begin
            half_class = dccd_pkg::CLS_BAD;
        end
    end

endmodule
`default_nettype wire

/* design/dccd_core.sv */
`default_nettype none
module dccd_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire dccd_pkg::cfg_t                 cfg,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [dccd_pkg::TICK_BITS-1:0] s_period_ticks,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [2:0]                          m_status,
    output logic [dccd_pkg::BYTE_BITS-1:0]      m_byte_value,
    output logic                                m_packet_end
);

    localparam int BB = dccd_pkg::BYTE_BITS;
    localparam int TB = dccd_pkg::TICK_BITS;

    logic          in_valid_reg;
    logic [TB-1:0] in_len_reg;

    dccd_pkg::phase_t               phase_reg, phase_next;
    logic [dccd_pkg::CNT_BITS-1:0]  count_reg, count_next;
    logic                           first_bit_reg, first_bit_next;
    logic [TB-1:0]                  first_len_reg, first_len_next;
    logic [dccd_pkg::BITS_LEFT_BITS-1:0] bits_left_reg, bits_left_next;
    logic [BB-1:0]                  shift_reg, shift_next;
    logic [BB-1:0]                  xor_reg, xor_next;

    logic                res_valid_reg;
    dccd_pkg::status_t   res_status_reg, res_status_next;
    logic [BB-1:0]       res_byte_reg, res_byte_next;
    logic                res_end_reg, res_end_next;
    logic                emit;

    dccd_pkg::half_class_t half_class;
    logic                  bit_val;
    logic [TB-1:0]         delta;
    logic                  proc;

    // advance the item in the input register only when the result slot frees up
    assign proc    = in_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_len_reg <= s_period_ticks;
        end
    end

    dccd_classify u_classify (
        .len        (in_len_reg),
        .cfg        (cfg),
        .half_class (half_class)
    );

    assign bit_val = (half_class == dccd_pkg::CLS_ONE);
    assign delta   = (in_len_reg > first_len_reg) ? in_len_reg - first_len_reg
                                                  : first_len_reg - in_len_reg;

    always_comb begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        first_bit_next  = first_bit_reg;
        first_len_next  = first_len_reg;
        bits_left_next  = bits_left_reg;
        shift_next      = shift_reg;
        xor_next        = xor_reg;
        emit            = 1'b0;
        res_status_next = dccd_pkg::ST_DATA;
        res_byte_next   = '0;
        res_end_next    = 1'b1;
        if (half_class == dccd_pkg::CLS_BAD) begin
            phase_next      = dccd_pkg::PH_SEEK;
            count_next      = '0;
            emit            = 1'b1;
            res_status_next = dccd_pkg::ST_BADLEN;
        end else begin
            unique case (phase_reg)
                dccd_pkg::PH_SEEK: begin
                    if (bit_val) begin
                        if (count_reg != dccd_pkg::PREAMBLE_SAT) begin
                            count_next = count_reg + 1'b1;
                        end
                    end else if (count_reg >= cfg.preamble_min) begin
                        phase_next = dccd_pkg::PH_START;
                    end else begin
                        count_next = '0;
                    end
                end
                dccd_pkg::PH_START: begin
                    if (bit_val) begin
                        phase_next = dccd_pkg::PH_SEEK;
                        count_next = '0;
                    end else begin
                        bits_left_next = dccd_pkg::BITS_PER_BYTE;
                        xor_next       = '0;
                        phase_next     = dccd_pkg::PH_A;
                    end
                end
                dccd_pkg::PH_A: begin
                    first_bit_next = bit_val;
                    first_len_next = in_len_reg;
                    phase_next     = dccd_pkg::PH_B;
                end
                dccd_pkg::PH_B: begin
                    if (first_bit_reg != bit_val) begin
                        phase_next      = dccd_pkg::PH_SEEK;
                        count_next      = '0;
                        emit            = 1'b1;
                        res_status_next = dccd_pkg::ST_MATCH;
                    end else if (bit_val && delta > cfg.one_delta_max) begin
                        phase_next      = dccd_pkg::PH_SEEK;
                        count_next      = '0;
                        emit            = 1'b1;
                        res_status_next = dccd_pkg::ST_DELTA;
                    end else if (bits_left_reg != '0) begin
                        shift_next     = {shift_reg[BB-2:0], bit_val};
                        bits_left_next = bits_left_reg - 1'b1;
                        phase_next     = dccd_pkg::PH_A;
                    end else if (!bit_val) begin
                        xor_next        = xor_reg ^ shift_reg;
                        bits_left_next  = dccd_pkg::BITS_PER_BYTE;
                        phase_next      = dccd_pkg::PH_A;
                        emit            = 1'b1;
                        res_status_next = dccd_pkg::ST_DATA;
                        res_byte_next   = shift_reg;
                        res_end_next    = 1'b0;
                    end else begin
                        phase_next      = dccd_pkg::PH_SEEK;
                        count_next      = '0;
                        emit            = 1'b1;
                        res_byte_next   = shift_reg;
                        res_status_next = (shift_reg != xor_reg) ? dccd_pkg::ST_CHECK
                                                                 : dccd_pkg::ST_OK;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= dccd_pkg::PH_SEEK;
            count_reg     <= '0;
            first_bit_reg <= 1'b0;
            first_len_reg <= '0;
            bits_left_reg <= '0;
            shift_reg     <= '0;
            xor_reg       <= '0;
        end else if (proc) begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            first_bit_reg <= first_bit_next;
            first_len_reg <= first_len_next;
            bits_left_reg <= bits_left_next;
            shift_reg     <= shift_next;
            xor_reg       <= xor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (proc) begin
            res_valid_reg <= emit;
        end else if (m_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && emit) begin
            res_status_reg <= res_status_next;
            res_byte_reg   <= res_byte_next;
            res_end_reg    <= res_end_next;
        end
    end

    assign m_valid      = res_valid_reg;
    assign m_status     = res_status_reg;
    assign m_byte_value = res_byte_reg;
    assign m_packet_end = res_end_reg;

    a_end_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg |-> (res_end_reg == (res_status_reg != dccd_pkg::ST_DATA)))
        else $error("packet_end disagrees with status");

    a_bits_left: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_left_reg <= dccd_pkg::BITS_PER_BYTE)
        else $error("bit counter out of range");

    a_end_resync: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && emit && res_end_next) |=>
            (phase_reg == dccd_pkg::PH_SEEK && count_reg == '0))
        else $error("no resync after packet end or error");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !m_ready) |-> !proc)
        else $error("result overwritten while stalled");

endmodule
`default_nettype wire

/* design/dcc_packet_decoder_core.sv */
`default_nettype none
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_period_ticks[15:0]
// m_        out        m_valid / m_ready    m_status[2:0], m_byte_value[7:0], m_packet_end
// cfg_      in         cfg_valid / cfg_ready cfg_index[2:0], cfg_data[15:0]
//
// One half-bit period per clock sustained while m_ready keeps results moving; each period
// is registered in the input register, then any result it gives in the result register.
// The state update is one pass of compare/shift logic between those registers.
// Reset clears the decoder state and loads the default thresholds.
// A stalled result holds the input register, then s_ready drops; cfg_ready is always high.
module dcc_packet_decoder_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [dccd_pkg::TICK_BITS-1:0]      s_period_ticks,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [2:0]                               m_status,
    output logic [dccd_pkg::BYTE_BITS-1:0]           m_byte_value,
    output logic                                     m_packet_end,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [dccd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [dccd_pkg::CFG_BITS-1:0]       cfg_data
);

    dccd_pkg::cfg_t cfg;

    assign cfg_ready = 1'b1;

    dccd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dccd_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_period_ticks (s_period_ticks),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_byte_value   (m_byte_value),
        .m_packet_end   (m_packet_end)
    );

endmodule
`default_nettype wire

/* tb/sv/tb_dcc_packet_decoder_core.sv */
`default_nettype none
module tb_dcc_packet_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_MAX         = (1 << dccd_pkg::TICK_BITS) - 1;
    localparam int DRAIN_CYCLES     = 8;
    localparam int SINK_HOLD_CYCLES = 200;
    localparam int FINAL_WAIT_LIMIT = 5000;
    localparam int RUN_LIMIT_NS     = 2_000_000;

    typedef struct packed {
        dccd_pkg::status_t              status;
        logic [dccd_pkg::BYTE_BITS-1:0] value;
        logic                           closes;
    } report_t;

    logic                                aclk           = 1'b0;
    logic                                aresetn        = 1'b0;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic [dccd_pkg::TICK_BITS-1:0]      s_period_ticks = '0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic [2:0]                          m_status;
    logic [dccd_pkg::BYTE_BITS-1:0]      m_byte_value;
    logic                                m_packet_end;
    logic                                cfg_valid      = 1'b0;
    logic                                cfg_ready;
    logic [dccd_pkg::CFG_INDEX_BITS-1:0] cfg_index      = '0;
    logic [dccd_pkg::CFG_BITS-1:0]       cfg_data       = '0;

    // decoder copy kept by the testbench
    dccd_pkg::cfg_t                      thresholds;
    dccd_pkg::phase_t                    sync_phase;
    logic [dccd_pkg::CNT_BITS-1:0]       ones_run;
    logic                                first_half_one;
    logic [dccd_pkg::TICK_BITS-1:0]      first_half_len;
    logic [dccd_pkg::BITS_LEFT_BITS-1:0] bits_to_go;
    logic [dccd_pkg::BYTE_BITS-1:0]      byte_sr;
    logic [dccd_pkg::BYTE_BITS-1:0]      packet_xor;

    report_t pending_reports[$];

    bit  src_idle   = 1'b1;
    bit  sink_idle  = 1'b0;
    bit  sink_hold  = 1'b0;
    int  sink_pause = 0;
    int  flaw_permille = 0;
    int  periods_sent = 0;
    int  reg_writes = 0;
    int  fault_count = 0;
    int  status_seen[0:7];

    dcc_packet_decoder_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_period_ticks (s_period_ticks),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_byte_value   (m_byte_value),
        .m_packet_end   (m_packet_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------- prediction

    function automatic void queue_report(input dccd_pkg::status_t st,
                                         input logic [dccd_pkg::BYTE_BITS-1:0] value,
                                         input logic closes);
        report_t r;
        r.status = st;
        r.value  = value;
        r.closes = closes;
        pending_reports.push_back(r);
    endfunction

    function automatic void lose_sync();
        ones_run   = '0;
        sync_phase = dccd_pkg::PH_SEEK;
    endfunction

    function automatic void decode_half_bit(input logic [dccd_pkg::TICK_BITS-1:0] len);
        dccd_pkg::half_class_t          cls;
        logic                           is_one;
        logic [dccd_pkg::TICK_BITS-1:0] diff;
        if (len >= thresholds.zero_min)
            cls = dccd_pkg::CLS_ZERO;
        else if (len >= thresholds.one_min && len <= thresholds.one_max)
            cls = dccd_pkg::CLS_ONE;
        else
            cls = dccd_pkg::CLS_BAD;
        is_one = (cls == dccd_pkg::CLS_ONE);
        if (cls == dccd_pkg::CLS_BAD) begin
            lose_sync();
            queue_report(dccd_pkg::ST_BADLEN, '0, 1'b1);
        end else begin
            case (sync_phase)
                dccd_pkg::PH_SEEK: begin
                    if (is_one) begin
                        if (ones_run != dccd_pkg::PREAMBLE_SAT)
                            ones_run++;
                    end else if (ones_run >= thresholds.preamble_min) begin
                        sync_phase = dccd_pkg::PH_START;
                    end else begin
                        ones_run = '0;
                    end
                end
                dccd_pkg::PH_START: begin
                    if (is_one) begin
                        lose_sync();
                    end else begin
                        bits_to_go = dccd_pkg::BITS_PER_BYTE;
                        packet_xor = '0;
                        sync_phase = dccd_pkg::PH_A;
                    end
                end
                dccd_pkg::PH_A: begin
                    first_half_one = is_one;
                    first_half_len = len;
                    sync_phase     = dccd_pkg::PH_B;
                end
                default: begin
                    diff = (len > first_half_len) ? len - first_half_len : first_half_len - len;
                    if (first_half_one != is_one) begin
                        lose_sync();
                        queue_report(dccd_pkg::ST_MATCH, '0, 1'b1);
                    end else if (is_one && diff > thresholds.one_delta_max) begin
                        lose_sync();
                        queue_report(dccd_pkg::ST_DELTA, '0, 1'b1);
                    end else if (bits_to_go != 0) begin
                        byte_sr    = {byte_sr[dccd_pkg::BYTE_BITS-2:0], is_one};
                        bits_to_go = bits_to_go - 1'b1;
                        sync_phase = dccd_pkg::PH_A;
                    end else if (!is_one) begin
                        packet_xor = packet_xor ^ byte_sr;
                        bits_to_go = dccd_pkg::BITS_PER_BYTE;
                        sync_phase = dccd_pkg::PH_A;
                        queue_report(dccd_pkg::ST_DATA, byte_sr, 1'b0);
                    end else begin
                        lose_sync();
                        queue_report((byte_sr == packet_xor) ? dccd_pkg::ST_OK
                                                             : dccd_pkg::ST_CHECK,
                                     byte_sr, 1'b1);
                    end
                end
            endcase
        end
    endfunction

    // ---------------------------------------------------------------- period choice

    function automatic logic [dccd_pkg::TICK_BITS-1:0] pick_zero();
        int unsigned lo;
        int unsigned hi;
        lo = 32'(thresholds.zero_min);
        hi = (lo > TICK_MAX - 40) ? TICK_MAX : lo + 40;
        if ($urandom_range(0, 3) == 0)
            hi = TICK_MAX;
        return 16'($urandom_range(lo, hi));
    endfunction

    // near: stay within the allowed delta of center
    function automatic logic [dccd_pkg::TICK_BITS-1:0] pick_one(input bit near, input int center);
        int lo;
        int hi;
        int d;
        lo = int'(thresholds.one_min);
        hi = int'(thresholds.one_max);
        d  = int'(thresholds.one_delta_max);
        if (hi >= int'(thresholds.zero_min))
            hi = int'(thresholds.zero_min) - 1;
        if (near) begin
            if (center - d > lo)
                lo = center - d;
            if (center + d < hi)
                hi = center + d;
        end
        if (lo > hi)
            return 16'($urandom);
        return 16'($urandom_range(lo, hi));
    endfunction

    function automatic logic [dccd_pkg::TICK_BITS-1:0] pick_bad();
        int unsigned v;
        int          tries;
        for (tries = 0; tries < 8; tries++) begin
            v = (thresholds.zero_min == 0) ? 0 : $urandom_range(0, thresholds.zero_min - 1);
            if (v < thresholds.one_min || v > thresholds.one_max)
                return 16'(v);
        end
        return 16'($urandom);
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_period(input logic [dccd_pkg::TICK_BITS-1:0] len);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_period_ticks <= len;
        do @(posedge aclk); while (!s_ready);
        decode_half_bit(len);
        periods_sent++;
    endtask

    // corrupt the odd half-bit when the packet is meant to be broken
    task automatic send_half(input logic [dccd_pkg::TICK_BITS-1:0] len);
        logic [dccd_pkg::TICK_BITS-1:0] v;
        v = len;
        if ($urandom_range(0, 999) < flaw_permille) begin
            case ($urandom_range(0, 2))
                0: v = pick_bad();
                1: v = pick_zero();
                default: v = pick_one(1'b0, 0);
            endcase
        end
        send_period(v);
    endtask

    task automatic send_bit(input logic is_one, input bit loose);
        logic [dccd_pkg::TICK_BITS-1:0] first;
        logic [dccd_pkg::TICK_BITS-1:0] second;
        if (is_one) begin
            first  = pick_one(1'b0, 0);
            second = pick_one(!loose, int'(first));
        end else begin
            first  = pick_zero();
            second = pick_zero();
        end
        send_half(first);
        send_half(second);
    endtask

    task automatic send_packet(input int n_bytes, input int preamble_halves, input bit flawed);
        logic [dccd_pkg::BYTE_BITS-1:0] data;
        logic [dccd_pkg::BYTE_BITS-1:0] checksum;
        int                             loose_pct;
        int                             i;
        int                             b;
        flaw_permille = flawed ? 25 : 0;
        loose_pct     = flawed ? 10 : 0;
        checksum      = '0;
        repeat (preamble_halves) send_half(pick_one(1'b0, 0));
        send_half(pick_zero());
        send_half(pick_zero());
        for (i = 0; i < n_bytes; i++) begin
            data = (i == n_bytes - 1) ? checksum : 8'($urandom);
            if (i == n_bytes - 1 && flawed && $urandom_range(0, 2) == 0)
                data = data ^ 8'($urandom_range(1, 255));
            for (b = dccd_pkg::BYTE_BITS - 1; b >= 0; b--)
                send_bit(data[b], $urandom_range(0, 99) < loose_pct);
            send_bit(i == n_bytes - 1, $urandom_range(0, 99) < loose_pct);
            checksum = checksum ^ data;
        end
        flaw_permille = 0;
    endtask

    task automatic send_noise(input int n);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: send_period(16'($urandom));
                1: send_period(pick_bad());
                2: send_period(pick_one(1'b0, 0));
                default: send_period(pick_zero());
            endcase
        end
    endtask

    // drop valid and let everything in flight drain out
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input dccd_pkg::reg_index_t idx,
                             input logic [dccd_pkg::CFG_BITS-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            dccd_pkg::REG_ZERO_MIN:  thresholds.zero_min      = value;
            dccd_pkg::REG_ONE_MIN:   thresholds.one_min       = value;
            dccd_pkg::REG_ONE_MAX:   thresholds.one_max       = value;
            dccd_pkg::REG_ONE_DELTA: thresholds.one_delta_max = value;
            dccd_pkg::REG_PREAMBLE:  thresholds.preamble_min  = value[dccd_pkg::CNT_BITS-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic load_thresholds(input logic [dccd_pkg::CFG_BITS-1:0] zero_min,
                                   input logic [dccd_pkg::CFG_BITS-1:0] one_min,
                                   input logic [dccd_pkg::CFG_BITS-1:0] one_max,
                                   input logic [dccd_pkg::CFG_BITS-1:0] one_delta,
                                   input logic [dccd_pkg::CNT_BITS-1:0] preamble);
        write_reg(dccd_pkg::REG_ZERO_MIN, zero_min);
        write_reg(dccd_pkg::REG_ONE_MIN, one_min);
        write_reg(dccd_pkg::REG_ONE_MAX, one_max);
        write_reg(dccd_pkg::REG_ONE_DELTA, one_delta);
        write_reg(dccd_pkg::REG_PREAMBLE, dccd_pkg::CFG_BITS'(preamble));
    endtask

    task automatic run_random_packets(input int budget);
        int start_count;
        int preamble;
        start_count = periods_sent;
        while (periods_sent - start_count < budget) begin
            src_idle = ($urandom_range(0, 3) != 0);
            sink_idle <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
                send_noise($urandom_range(1, 8));
            preamble = thresholds.preamble_min + $urandom_range(0, 4);
            if ($urandom_range(0, 7) == 0)
                preamble = $urandom_range(0, thresholds.preamble_min);
            send_packet($urandom_range(1, 5), preamble, $urandom_range(0, 9) < 3);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_length_classes();
        send_period(16'd0);
        send_period(dccd_pkg::ONE_MIN_RESET - 1'b1);
        send_period(dccd_pkg::ONE_MIN_RESET);
        send_period(dccd_pkg::ONE_MAX_RESET);
        send_period(dccd_pkg::ONE_MAX_RESET + 1'b1);
        send_period(dccd_pkg::ZERO_MIN_RESET - 1'b1);
        send_period(dccd_pkg::ZERO_MIN_RESET);
        send_period(16'hFFFF);
    endtask

    task automatic test_preamble_rules();
        write_reg(dccd_pkg::REG_PREAMBLE, 16'd2);
        // too few ones, then a clean start followed by a one
        send_period(16'd110);
        send_period(16'd200);
        send_period(16'd110);
        send_period(16'd120);
        send_period(16'd200);
        send_period(16'd115);
    endtask

    task automatic test_bit_errors();
        write_reg(dccd_pkg::REG_PREAMBLE, 16'd0);
        send_period(16'd200);
        send_period(16'd200);
        send_period(16'd110);
        send_period(16'd200);
        send_period(16'd200);
        send_period(16'd200);
        send_period(dccd_pkg::ONE_MIN_RESET);
        send_period(dccd_pkg::ONE_MAX_RESET);
    endtask

    task automatic test_default_traffic();
        load_thresholds(dccd_pkg::ZERO_MIN_RESET, dccd_pkg::ONE_MIN_RESET,
                        dccd_pkg::ONE_MAX_RESET, dccd_pkg::ONE_DELTA_RESET,
                        dccd_pkg::PREAMBLE_RESET);
        run_random_packets(150);
    endtask

    task automatic test_random_thresholds();
        int omin;
        int omax;
        int zmin;
        int round;
        for (round = 0; round < 4; round++) begin
            omin = $urandom_range(1, 3000);
            omax = omin + $urandom_range(0, 600);
            // overlap the zero window now and then; zero wins there
            if ($urandom_range(0, 3) == 0)
                zmin = $urandom_range(omin + 1, omax + 1);
            else
                zmin = omax + 1 + $urandom_range(0, 2000);
            load_thresholds(16'(zmin), 16'(omin), 16'(omax),
                            (round == 0) ? 16'd0 : 16'($urandom_range(1, 80)),
                            8'($urandom_range(0, 10)));
            run_random_packets(70);
        end
    endtask

    // every period is a zero: the decoder starts at once and emits zero bytes
    task automatic test_all_zero_thresholds();
        load_thresholds('0, '0, '0, '0, '0);
        src_idle = 1'b1;
        sink_idle <= 1'b1;
        send_noise(80);
    endtask

    // widest one window and the longest preamble; the count saturates
    task automatic test_wide_one_window();
        load_thresholds(16'hFFFF, '0, 16'hFFFF, 16'hFFFF, 8'hFF);
        src_idle = 1'b0;
        sink_idle <= 1'b0;
        send_packet(3, 255 + $urandom_range(1, 8), 1'b0);
        send_noise(10);
    endtask

    task automatic test_stalled_sink();
        load_thresholds(dccd_pkg::ZERO_MIN_RESET, dccd_pkg::ONE_MIN_RESET,
                        dccd_pkg::ONE_MAX_RESET, dccd_pkg::ONE_DELTA_RESET, 8'd2);
        src_idle = 1'b0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                sink_hold <= 1'b0;
            end
            repeat (3) send_packet(3, 2, 1'b0);
        join
    endtask

    // ---------------------------------------------------------------- result side

    always @(posedge aclk) begin : result_sink
        int unsigned pause;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            sink_pause <= 0;
        end else if (sink_hold) begin
            m_ready <= 1'b0;
        end else if (m_ready && m_valid) begin
            pause = sink_idle ? $urandom_range(0, 4) : 0;
            m_ready    <= (pause == 0);
            sink_pause <= pause;
        end else if (!m_ready) begin
            if (sink_pause > 1) begin
                sink_pause <= sink_pause - 1;
            end else begin
                m_ready    <= 1'b1;
                sink_pause <= 0;
            end
        end
    end

    always @(posedge aclk) begin : report_check
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            status_seen[m_status]++;
            if (pending_reports.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected report: status %0d byte %02h end %0b",
                             m_status, m_byte_value, m_packet_end);
            end else begin
                want = pending_reports.pop_front();
                if (m_status !== want.status || m_byte_value !== want.value ||
                    m_packet_end !== want.closes) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: expected status %0d byte %02h end %0b, got %0d %02h %0b",
                                 want.status, want.value, want.closes,
                                 m_status, m_byte_value, m_packet_end);
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        int waited;
        thresholds.zero_min      = dccd_pkg::ZERO_MIN_RESET;
        thresholds.one_min       = dccd_pkg::ONE_MIN_RESET;
        thresholds.one_max       = dccd_pkg::ONE_MAX_RESET;
        thresholds.one_delta_max = dccd_pkg::ONE_DELTA_RESET;
        thresholds.preamble_min  = dccd_pkg::PREAMBLE_RESET;
        sync_phase     = dccd_pkg::PH_SEEK;
        ones_run       = '0;
        first_half_one = 1'b0;
        first_half_len = '0;
        bits_to_go     = '0;
        byte_sr        = '0;
        packet_xor     = '0;
        for (int k = 0; k < 8; k++)
            status_seen[k] = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_length_classes();
        test_preamble_rules();
        test_bit_errors();
        test_default_traffic();
        test_random_thresholds();
        test_all_zero_thresholds();
        test_wide_one_window();
        test_stalled_sink();

        s_valid <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < FINAL_WAIT_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_reports.size() != 0) begin
            fault_count++;
            $display("%0d reports never arrived", pending_reports.size());
        end

        $display("Sent %0d half-bit periods over %0d threshold writes, incl. a long sink stall",
                 periods_sent, reg_writes);
        $display("Reports: %0d data, %0d ok, %0d check, %0d length, %0d match, %0d delta",
                 status_seen[dccd_pkg::ST_DATA], status_seen[dccd_pkg::ST_OK],
                 status_seen[dccd_pkg::ST_CHECK], status_seen[dccd_pkg::ST_BADLEN],
                 status_seen[dccd_pkg::ST_MATCH], status_seen[dccd_pkg::ST_DELTA]);
        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("run limit reached");
        $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
